>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked after the antecedent with |=> followed by ##1
`define ASSERT_LATER(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

>>> hdl/bgd_pkg.sv
// Types and constants of the button gesture detector.
// No dependencies; bgd_cfg, bgd_core and the top level import this package.
`default_nettype none

package bgd_pkg;

    localparam int unsigned ThrW  = 16;
    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIdxW = 2;

    // Gesture codes on the result channel
    typedef enum logic [2:0] {
        GEST_NONE     = 3'd0,
        GEST_CLICK    = 3'd1,
        GEST_RELEASED = 3'd2,
        GEST_HOLD     = 3'd3,
        GEST_LONG     = 3'd4
    } gesture_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DBL_GAP   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD      = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_LONG_HOLD = 2'd3;

    // Reset values of the thresholds
    localparam logic [ThrW-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [ThrW-1:0] DBL_GAP_RST   = 16'd250;
    localparam logic [ThrW-1:0] HOLD_RST      = 16'd1000;
    localparam logic [ThrW-1:0] LONG_HOLD_RST = 16'd3000;

    // Thresholds handed from the register bank to the core
    typedef struct packed {
        logic [ThrW-1:0] debounce_ms;
        logic [ThrW-1:0] double_click_gap_ms;
        logic [ThrW-1:0] hold_ms;
        logic [ThrW-1:0] long_hold_ms;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/bgd_sample_if.sv
// Sample channel: valid/ready handshake with button level and timestamp.
// Depends on nothing.
`default_nettype none

interface bgd_sample_if;
    logic        valid;
    logic        ready;
    logic        button_level;
    logic [31:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink (input valid, input button_level, input now_ms, output ready);
endinterface

`default_nettype wire

>>> hdl/bgd_gesture_if.sv
// Gesture channel: valid/ready handshake with a 3-bit gesture code.
// Depends on nothing.
`default_nettype none

interface bgd_gesture_if;
    logic       valid;
    logic       ready;
    logic [2:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink (input valid, input gesture, output ready);
endinterface

`default_nettype wire

>>> hdl/bgd_cfg.sv
// Threshold register bank written through the plain write port.
// Depends on bgd_pkg.
`default_nettype none

module bgd_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bgd_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [bgd_pkg::ThrW-1:0]    cfg_wdata,
    output bgd_pkg::cfg_t                    cfg
);
    import bgd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:  cfg_next.debounce_ms         = cfg_wdata;
                CFG_DBL_GAP:   cfg_next.double_click_gap_ms = cfg_wdata;
                CFG_HOLD:      cfg_next.hold_ms             = cfg_wdata;
                CFG_LONG_HOLD: cfg_next.long_hold_ms        = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= DEBOUNCE_RST;
            cfg_reg.double_click_gap_ms <= DBL_GAP_RST;
            cfg_reg.hold_ms             <= HOLD_RST;
            cfg_reg.long_hold_ms        <= LONG_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/bgd_core.sv
// Gesture state and the per-sample decision logic.
// Depends on bgd_pkg.
`default_nettype none

module bgd_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step_en,
    input  wire logic                      level,
    input  wire logic [bgd_pkg::TimeW-1:0] now,
    input  wire bgd_pkg::cfg_t             cfg,
    output bgd_pkg::gesture_t              gesture
);
    import bgd_pkg::*;

    logic             last_level_reg, last_level_next;
    logic [TimeW-1:0] press_time_reg, press_time_next;
    logic [TimeW-1:0] release_time_reg, release_time_next;
    logic             ignore_release_reg, ignore_release_next;
    logic             single_allowed_reg, single_allowed_next;
    logic             hold_done_reg, hold_done_next;
    logic             long_done_reg, long_done_next;
    logic             dbl_on_rel_reg, dbl_on_rel_next;
    logic             await_dbl_reg, await_dbl_next;

    logic [TimeW-1:0] deb_w, gap_w, hold_w, long_w;

    assign deb_w  = {{(TimeW-ThrW){1'b0}}, cfg.debounce_ms};
    assign gap_w  = {{(TimeW-ThrW){1'b0}}, cfg.double_click_gap_ms};
    assign hold_w = {{(TimeW-ThrW){1'b0}}, cfg.hold_ms};
    assign long_w = {{(TimeW-ThrW){1'b0}}, cfg.long_hold_ms};

    // One step: edge handling, click timeout, hold detection
    always_comb
    begin
        logic [TimeW-1:0] since_rel;
        logic [TimeW-1:0] since_press;
        gesture_t         g;

        since_rel   = now - release_time_reg;
        since_press = now - press_time_reg;
        g           = GEST_NONE;

        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        ignore_release_next = ignore_release_reg;
        single_allowed_next = single_allowed_reg;
        hold_done_next      = hold_done_reg;
        long_done_next      = long_done_reg;
        dbl_on_rel_next     = dbl_on_rel_reg;
        await_dbl_next      = await_dbl_reg;

        // Debounced press or release edge
        if (!level && last_level_reg && (since_rel > deb_w))
        begin
            press_time_next     = now;
            since_press         = '0;
            ignore_release_next = 1'b0;
            single_allowed_next = 1'b1;
            hold_done_next      = 1'b0;
            long_done_next      = 1'b0;
            dbl_on_rel_next     = (since_rel < gap_w) && !dbl_on_rel_reg && await_dbl_reg;
            await_dbl_next      = 1'b0;
        end
        else if (level && !last_level_reg && (since_press > deb_w))
        begin
            if (!ignore_release_reg)
            begin
                release_time_next = now;
                since_rel         = '0;
                if (!dbl_on_rel_reg)
                begin
                    await_dbl_next = 1'b1;
                end
                else
                begin
                    g                   = GEST_RELEASED;
                    dbl_on_rel_next     = 1'b0;
                    await_dbl_next      = 1'b0;
                    single_allowed_next = 1'b0;
                end
            end
        end

        // Gap expired with no second press: single click
        if (level && (since_rel >= gap_w) && await_dbl_next && !dbl_on_rel_next
            && single_allowed_next && (g != GEST_RELEASED))
        begin
            g              = GEST_CLICK;
            await_dbl_next = 1'b0;
        end

        // Hold, then long hold; long hold wins in the same step
        if (!level && (since_press >= hold_w))
        begin
            if (!hold_done_next)
            begin
                g                   = GEST_HOLD;
                ignore_release_next = 1'b1;
                dbl_on_rel_next     = 1'b0;
                await_dbl_next      = 1'b0;
                hold_done_next      = 1'b1;
            end
            if ((since_press >= long_w) && !long_done_next)
            begin
                g              = GEST_LONG;
                long_done_next = 1'b1;
            end
        end

        last_level_next = level;
        gesture         = g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b1;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            ignore_release_reg <= 1'b0;
            single_allowed_reg <= 1'b0;
            hold_done_reg      <= 1'b0;
            long_done_reg      <= 1'b0;
            dbl_on_rel_reg     <= 1'b0;
            await_dbl_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            last_level_reg     <= last_level_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            ignore_release_reg <= ignore_release_next;
            single_allowed_reg <= single_allowed_next;
            hold_done_reg      <= hold_done_next;
            long_done_reg      <= long_done_next;
            dbl_on_rel_reg     <= dbl_on_rel_next;
            await_dbl_reg      <= await_dbl_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/button_gesture_detector_unit.sv
// Button gesture detector, top level.
// Usage:
//   sample  : request with button_level (0 pressed) and now_ms; one gesture
//             code comes back for every request, in order.
//   gesture : request with a code: 0 none, 1 click, 2 double-click release,
//             3 hold, 4 long hold.
//   cfg_*   : write port for debounce, double-click gap, hold and long hold
//             thresholds in ms; write only while no request is in flight.
// Path: an accepted request waits in the input register; its gesture is
//   loaded into the result register when the step fires.
// Throughput: one request per cycle while results are taken; the whole step
//   sits between the input and result registers and updates the state.
// Stall: a held result keeps its value; the input register still takes one
//   more request, after which sample.ready drops until the result is taken.
// Reset: rst_n (async, active low) empties both registers, restores the
//   default thresholds and returns the gesture state to released/idle.
// Depends on bgd_pkg, bgd_sample_if, bgd_gesture_if, bgd_cfg, bgd_core.
`default_nettype none

module button_gesture_detector_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bgd_sample_if.sink                       sample,
    bgd_gesture_if.source                    result,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bgd_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [bgd_pkg::ThrW-1:0]    cfg_wdata
);
    import bgd_pkg::*;

    cfg_t             cfg;
    logic             in_valid_reg, in_valid_next;
    logic             level_reg;
    logic [TimeW-1:0] now_reg;
    logic             out_valid_reg, out_valid_next;
    gesture_t         gest_reg;
    gesture_t         gest_step;
    logic             out_adv;
    logic             step_en;
    logic             in_take;

    // Handshake: the step fires when the result register can load
    assign out_adv      = !out_valid_reg || result.ready;
    assign step_en      = in_valid_reg && out_adv;
    assign sample.ready = !in_valid_reg || out_adv;
    assign in_take      = sample.valid && sample.ready;

    assign in_valid_next  = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_en ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    bgd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .level   (level_reg),
        .now     (now_reg),
        .cfg     (cfg),
        .gesture (gest_step)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            level_reg <= sample.button_level;
            now_reg   <= sample.now_ms;
        end
        if (step_en)
        begin
            gest_reg <= gest_step;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.gesture = gest_reg;

endmodule

`default_nettype wire

>>> hdl/bgd_checker.sv
// Port-level checks of the button gesture detector, bound to the top level.
// Depends on assert_macros.svh and button_gesture_detector_unit.
`default_nettype none

`include "assert_macros.svh"

module bgd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       sample_valid,
    input wire logic       sample_ready,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [2:0] result_gesture
);

    // A stalled result keeps its code
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_gesture), "stalled gesture changed")

    // With the result register empty, a request is always taken
    `ASSERT_SAME(a_ready_when_idle, clk, rst_n, !result_valid, sample_ready, "sample not ready with empty result register")

    // Every accepted request has a result showing, checked with ASSERT_LATER
    `ASSERT_LATER(a_result_follows, clk, rst_n, sample_valid && sample_ready, result_valid, "no gesture after accepted sample")

endmodule

bind button_gesture_detector_unit bgd_checker u_bgd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_gesture (result.gesture)
);

`default_nettype wire
